@@ src/cell_volume_centroid_unit_macros.svh @@
// Assertion helpers used by the checker of this block.
`ifndef CELL_VOLUME_CENTROID_UNIT_MACROS_SVH
`define CELL_VOLUME_CENTROID_UNIT_MACROS_SVH

// General form: explicit clock and active-low reset.
`define CVC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Usual form on clk_i / rst_ni.
`define CVC_ASSERT_CLK(lbl, prop, msg) \
  `CVC_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ src/cvc_pkg.sv @@
package cvc_pkg;

  localparam int unsigned MaxNodes = 8;
  localparam int unsigned VolBits  = 58;
  localparam int unsigned CentBits = 24;
  localparam int unsigned QuoBits  = 24;
  localparam logic [4:0]  CalcLast = 5'd18;
  localparam logic [4:0]  DivLast  = 5'(QuoBits + 1);

  localparam logic [CentBits-1:0] CentSat = 24'h800000;
  localparam logic [CentBits-1:0] CentMax = 24'h7FFFFF;

  // result status
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadCount = 2'd1;
  localparam logic [1:0] StZeroVol  = 2'd2;

  // wide multiplier operand
  localparam logic [2:0] ASelV0  = 3'd0;
  localparam logic [2:0] ASelV1  = 3'd1;
  localparam logic [2:0] ASelV2  = 3'd2;
  localparam logic [2:0] ASelX   = 3'd3;
  localparam logic [2:0] ASelWlo = 3'd4;
  localparam logic [2:0] ASelWhi = 3'd5;

  // narrow multiplier operand
  localparam logic [3:0] BSelW0 = 4'd0;
  localparam logic [3:0] BSelW1 = 4'd1;
  localparam logic [3:0] BSelW2 = 4'd2;
  localparam logic [3:0] BSelU0 = 4'd3;
  localparam logic [3:0] BSelU1 = 4'd4;
  localparam logic [3:0] BSelU2 = 4'd5;
  localparam logic [3:0] BSelS0 = 4'd6;
  localparam logic [3:0] BSelS1 = 4'd7;
  localparam logic [3:0] BSelS2 = 4'd8;

  // datapath operations
  localparam logic [3:0] OpNop   = 4'd0;
  localparam logic [3:0] OpClr   = 4'd1;
  localparam logic [3:0] OpXSet  = 4'd2;
  localparam logic [3:0] OpXSub  = 4'd3;
  localparam logic [3:0] OpDSet  = 4'd4;
  localparam logic [3:0] OpDAdd  = 4'd5;
  localparam logic [3:0] OpDSub  = 4'd6;
  localparam logic [3:0] OpVol   = 4'd7;
  localparam logic [3:0] OpALo   = 4'd8;
  localparam logic [3:0] OpAHi   = 4'd9;
  localparam logic [3:0] OpDInit = 4'd10;
  localparam logic [3:0] OpDStep = 4'd11;
  localparam logic [3:0] OpDDone = 4'd12;
  localparam logic [3:0] OpOut   = 4'd13;

  // leaf tetrahedra: tet, pyramid, prism, hexahedron
  localparam logic [2:0] LeafTets [12][4] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3},
    '{3'd0, 3'd1, 3'd2, 3'd4}, '{3'd0, 3'd2, 3'd3, 3'd4},
    '{3'd0, 3'd1, 3'd4, 3'd5}, '{3'd0, 3'd4, 3'd3, 3'd5}, '{3'd0, 3'd1, 3'd2, 3'd5},
    '{3'd0, 3'd1, 3'd5, 3'd6}, '{3'd0, 3'd5, 3'd4, 3'd6}, '{3'd0, 3'd1, 3'd2, 3'd6},
    '{3'd0, 3'd2, 3'd6, 3'd7}, '{3'd0, 3'd6, 3'd4, 3'd7}, '{3'd0, 3'd2, 3'd3, 3'd7}
  };

  typedef struct packed {
    logic [2:0] a_sel;
    logic [3:0] b_sel;
    logic [3:0] op;
    logic [1:0] axis;
  } cvc_sched_t;

  typedef struct packed {
    logic       wr_en;
    logic [2:0] wr_addr;
    logic       rd_en;
    logic [2:0] rd_addr;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic [2:0] a_sel;
    logic [3:0] b_sel;
    logic [3:0] op;
    logic [1:0] axis;
    logic       tet;
    logic [1:0] status;
  } cvc_cmd_t;

  typedef struct packed {
    logic vsum_zero;
  } cvc_stat_t;

  // per-tet schedule: cross products, triple product, then weighted sums
  function automatic cvc_sched_t sched(input logic [4:0] step);
    cvc_sched_t s;
    s = '{a_sel: ASelV0, b_sel: BSelW0, op: OpNop, axis: 2'd0};
    case (step)
      5'd0: begin
        s.a_sel = ASelV1; s.b_sel = BSelW2;
      end
      5'd1: begin
        s.a_sel = ASelV2; s.b_sel = BSelW1; s.op = OpXSet;
      end
      5'd2: begin
        s.a_sel = ASelV0; s.b_sel = BSelW2; s.op = OpXSub;
      end
      5'd3: begin
        s.a_sel = ASelX; s.b_sel = BSelU0; s.op = OpXSet;
      end
      5'd4: begin
        s.a_sel = ASelV2; s.b_sel = BSelW0; s.op = OpDSet;
      end
      5'd5: begin
        s.a_sel = ASelV0; s.b_sel = BSelW1; s.op = OpXSub;
      end
      5'd6: begin
        s.a_sel = ASelX; s.b_sel = BSelU1; s.op = OpXSet;
      end
      5'd7: begin
        s.a_sel = ASelV1; s.b_sel = BSelW0; s.op = OpDSub;
      end
      5'd8: begin
        s.op = OpXSub;
      end
      5'd9: begin
        s.a_sel = ASelX; s.b_sel = BSelU2;
      end
      5'd10: begin
        s.op = OpDAdd;
      end
      5'd11: begin
        s.op = OpVol;
      end
      5'd12: begin
        s.a_sel = ASelWlo; s.b_sel = BSelS0;
      end
      5'd13: begin
        s.a_sel = ASelWhi; s.b_sel = BSelS0; s.op = OpALo; s.axis = 2'd0;
      end
      5'd14: begin
        s.a_sel = ASelWlo; s.b_sel = BSelS1; s.op = OpAHi; s.axis = 2'd0;
      end
      5'd15: begin
        s.a_sel = ASelWhi; s.b_sel = BSelS1; s.op = OpALo; s.axis = 2'd1;
      end
      5'd16: begin
        s.a_sel = ASelWlo; s.b_sel = BSelS2; s.op = OpAHi; s.axis = 2'd1;
      end
      5'd17: begin
        s.a_sel = ASelWhi; s.b_sel = BSelS2; s.op = OpALo; s.axis = 2'd2;
      end
      5'd18: begin
        s.op = OpAHi; s.axis = 2'd2;
      end
      default: begin
        s.op = OpNop;
      end
    endcase
    return s;
  endfunction

endpackage

@@ src/cvc_if.sv @@
interface cvc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] node_x;
  logic signed [15:0] node_y;
  logic signed [15:0] node_z;
  logic               last_node;

  modport source (output valid, node_x, node_y, node_z, last_node, input ready);
  modport sink   (input valid, node_x, node_y, node_z, last_node, output ready);
endinterface

interface cvc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [57:0]        six_volume;
  logic signed [23:0] centroid_x;
  logic signed [23:0] centroid_y;
  logic signed [23:0] centroid_z;

  modport source (output valid, status, six_volume, centroid_x, centroid_y, centroid_z,
                  input ready);
  modport sink   (input valid, status, six_volume, centroid_x, centroid_y, centroid_z,
                  output ready);
endinterface

@@ src/cvc_controller.sv @@
module cvc_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_last_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  cvc_pkg::cvc_stat_t   stat_i,
  output cvc_pkg::cvc_cmd_t    cmd_o
);

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_CALC = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [3:0] nodes_q, nodes_d;
  logic       ovf_q, ovf_d;
  logic       tet_q, tet_d;
  logic [3:0] first_q, first_d;
  logic [2:0] ntet_q, ntet_d;
  logic [2:0] ti_q, ti_d;
  logic [1:0] axis_q, axis_d;
  logic [1:0] status_q, status_d;
  logic       out_valid_q, out_valid_d;

  logic       in_xfer;
  logic       room;
  logic [3:0] nodes_new;
  logic       ovf_new;
  logic       good;
  logic [3:0] row;
  cvc_pkg::cvc_sched_t sc;

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign room        = (nodes_q < 4'(cvc_pkg::MaxNodes));
  assign nodes_new   = nodes_q + {3'b000, room};
  assign ovf_new     = ovf_q || !room;
  assign good        = !ovf_new && (nodes_new inside {4'd4, 4'd5, 4'd6, 4'd8});
  assign row         = first_q + {1'b0, ti_q};
  assign sc          = cvc_pkg::sched(cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    nodes_d     = nodes_q;
    ovf_d       = ovf_q;
    tet_d       = tet_q;
    first_d     = first_q;
    ntet_d      = ntet_q;
    ti_d        = ti_q;
    axis_d      = axis_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;

    cmd_o         = '0;
    cmd_o.wr_addr = nodes_q[2:0];
    cmd_o.rd_addr = cvc_pkg::LeafTets[row][cnt_q[1:0]];
    cmd_o.cap_sel = cnt_q[1:0] - 2'd1;
    cmd_o.a_sel   = cvc_pkg::ASelV0;
    cmd_o.b_sel   = cvc_pkg::BSelW0;
    cmd_o.op      = cvc_pkg::OpNop;
    cmd_o.axis    = axis_q;
    cmd_o.tet     = tet_q;
    cmd_o.status  = status_q;

    case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          cmd_o.wr_en = room;
          if (in_last_i) begin
            nodes_d = 4'd0;
            ovf_d   = 1'b0;
            if (good) begin
              cmd_o.op = cvc_pkg::OpClr;
              case (nodes_new)
                4'd5: begin
                  first_d = 4'd1; ntet_d = 3'd2; tet_d = 1'b0;
                end
                4'd6: begin
                  first_d = 4'd3; ntet_d = 3'd3; tet_d = 1'b0;
                end
                4'd8: begin
                  first_d = 4'd6; ntet_d = 3'd6; tet_d = 1'b0;
                end
                default: begin
                  first_d = 4'd0; ntet_d = 3'd1; tet_d = 1'b1;
                end
              endcase
              ti_d    = 3'd0;
              cnt_d   = 5'd0;
              state_d = ST_READ;
            end else begin
              status_d = cvc_pkg::StBadCount;
              state_d  = ST_FIN;
            end
          end else begin
            nodes_d = nodes_new;
            ovf_d   = ovf_new;
          end
        end
      end
      ST_READ: begin
        // read data lands in the cycle after its address
        cmd_o.rd_en  = (cnt_q < 5'd4);
        cmd_o.cap_en = (cnt_q != 5'd0);
        if (cnt_q == 5'd4) begin
          cnt_d   = 5'd0;
          state_d = ST_CALC;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_CALC: begin
        cmd_o.a_sel = sc.a_sel;
        cmd_o.b_sel = sc.b_sel;
        cmd_o.op    = sc.op;
        cmd_o.axis  = sc.axis;
        if (cnt_q == cvc_pkg::CalcLast) begin
          cnt_d = 5'd0;
          if (ti_q == ntet_q - 3'd1) begin
            if (!tet_q && stat_i.vsum_zero) begin
              status_d = cvc_pkg::StZeroVol;
              state_d  = ST_FIN;
            end else begin
              axis_d  = 2'd0;
              state_d = ST_DIV;
            end
          end else begin
            ti_d    = ti_q + 3'd1;
            state_d = ST_READ;
          end
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_DIV: begin
        if (cnt_q == 5'd0) begin
          cmd_o.op = cvc_pkg::OpDInit;
        end else if (cnt_q == cvc_pkg::DivLast) begin
          cmd_o.op = cvc_pkg::OpDDone;
        end else begin
          cmd_o.op = cvc_pkg::OpDStep;
        end
        if (cnt_q == cvc_pkg::DivLast) begin
          cnt_d = 5'd0;
          if (axis_q == 2'd2) begin
            status_d = cvc_pkg::StOk;
            state_d  = ST_FIN;
          end else begin
            axis_d = axis_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = cvc_pkg::OpOut;
          out_valid_d = 1'b1;
          state_d     = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= 5'd0;
      nodes_q     <= 4'd0;
      ovf_q       <= 1'b0;
      tet_q       <= 1'b0;
      first_q     <= 4'd0;
      ntet_q      <= 3'd1;
      ti_q        <= 3'd0;
      axis_q      <= 2'd0;
      status_q    <= cvc_pkg::StOk;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      nodes_q     <= nodes_d;
      ovf_q       <= ovf_d;
      tet_q       <= tet_d;
      first_q     <= first_d;
      ntet_q      <= ntet_d;
      ti_q        <= ti_d;
      axis_q      <= axis_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/cvc_datapath.sv @@
module cvc_datapath #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                 clk_i,
  input  cvc_pkg::cvc_cmd_t    cmd_i,
  input  logic [15:0]          node_x_i,
  input  logic [15:0]          node_y_i,
  input  logic [15:0]          node_z_i,
  output cvc_pkg::cvc_stat_t   stat_o,
  output logic [1:0]           status_o,
  output logic [57:0]          six_volume_o,
  output logic signed [23:0]   centroid_x_o,
  output logic signed [23:0]   centroid_y_o,
  output logic signed [23:0]   centroid_z_o
);

  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned DW  = CB + 1;          // edge vector
  localparam int unsigned SW  = CB + 2;          // sum of four nodes
  localparam int unsigned CW  = 2 * DW + 1;      // cross product term
  localparam int unsigned TW  = 3 * DW + 3;      // triple product
  localparam int unsigned HW  = (TW + 1) / 2;    // low half of the weight
  localparam int unsigned MA  = (CW > HW + 1) ? CW : HW + 1;
  localparam int unsigned MB  = SW;
  localparam int unsigned PW  = MA + MB;
  localparam int unsigned VW  = TW + 3;          // sum of up to six volumes
  localparam int unsigned AW  = VW + SW;         // weighted coordinate sum
  localparam int unsigned EW  = AW + PW;
  localparam int unsigned DNW = (VW + 2 > 64) ? 64 : VW + 2;
  localparam int unsigned DVW = (VW + 3 > 64) ? 64 : VW + 3;
  localparam int unsigned NSW = AW + FRAC_BITS + 1;
  localparam int unsigned XW  = ((NSW > DNW) ? NSW : DNW) + 1;
  localparam int unsigned QB  = cvc_pkg::QuoBits;
  localparam int unsigned CMW = XW + DVW + QB;
  localparam int unsigned OVW = cvc_pkg::VolBits;
  localparam int unsigned SVW = (VW > OVW) ? VW : OVW;

  logic [3*CB-1:0] mem_q [cvc_pkg::MaxNodes];
  logic [3*CB-1:0] rdata_q;
  logic [CB+15:0]  ext_x, ext_y, ext_z;

  logic signed [CB-1:0] pt_q [4][3];
  logic signed [DW-1:0] u [3];
  logic signed [DW-1:0] v [3];
  logic signed [DW-1:0] w [3];
  logic signed [SW-1:0] s [3];

  logic signed [MA-1:0] a_op;
  logic signed [MB-1:0] b_op;
  logic signed [PW-1:0] prod_q;
  logic signed [EW-1:0] pext;
  logic signed [EW-1:0] pshift;

  logic signed [CW-1:0] x_q;
  logic signed [TW-1:0] d_q;
  logic [TW-1:0]        w_q;
  logic [TW-1:0]        dabs;
  logic [VW-1:0]        vsum_q;
  logic signed [AW-1:0] acc_q [3];

  logic [DNW-1:0]       den4;
  logic [DVW-1:0]       dvs;
  logic [AW-1:0]        mag;
  logic [XW-1:0]        dividend;
  logic [DVW:0]         rem_q;
  logic [DVW:0]         rem2;
  logic                 ge;
  logic [QB-1:0]        qs_q;
  logic                 neg_q;
  logic                 ovf_q;
  logic [23:0]          qc;
  logic [23:0]          cent;
  logic [23:0]          cent_q [3];
  logic [SVW-1:0]       vsum_ext;
  logic [OVW-1:0]       vsum_sat;

  logic [1:0]           status_q;
  logic [57:0]          six_q;
  logic [23:0]          cx_q, cy_q, cz_q;

  // coordinates take the low COORD_BITS bits as two's complement
  assign ext_x = {{CB{1'b0}}, node_x_i};
  assign ext_y = {{CB{1'b0}}, node_y_i};
  assign ext_z = {{CB{1'b0}}, node_z_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= {ext_z[CB-1:0], ext_y[CB-1:0], ext_x[CB-1:0]};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      for (int k = 0; k < 3; k++) begin
        pt_q[cmd_i.cap_sel][k] <= rdata_q[k*CB +: CB];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u[k] = DW'(pt_q[1][k]) - DW'(pt_q[0][k]);
      v[k] = DW'(pt_q[2][k]) - DW'(pt_q[0][k]);
      w[k] = DW'(pt_q[3][k]) - DW'(pt_q[0][k]);
      s[k] = SW'(pt_q[0][k]) + SW'(pt_q[1][k]) + SW'(pt_q[2][k]) + SW'(pt_q[3][k]);
    end
  end

  always_comb begin
    case (cmd_i.a_sel)
      cvc_pkg::ASelV0:  a_op = MA'(v[0]);
      cvc_pkg::ASelV1:  a_op = MA'(v[1]);
      cvc_pkg::ASelV2:  a_op = MA'(v[2]);
      cvc_pkg::ASelX:   a_op = MA'(x_q);
      cvc_pkg::ASelWlo: a_op = $signed(MA'(w_q[HW-1:0]));
      cvc_pkg::ASelWhi: a_op = $signed(MA'(w_q[TW-1:HW]));
      default:          a_op = '0;
    endcase
    case (cmd_i.b_sel)
      cvc_pkg::BSelW0: b_op = MB'(w[0]);
      cvc_pkg::BSelW1: b_op = MB'(w[1]);
      cvc_pkg::BSelW2: b_op = MB'(w[2]);
      cvc_pkg::BSelU0: b_op = MB'(u[0]);
      cvc_pkg::BSelU1: b_op = MB'(u[1]);
      cvc_pkg::BSelU2: b_op = MB'(u[2]);
      cvc_pkg::BSelS0: b_op = s[0];
      cvc_pkg::BSelS1: b_op = s[1];
      cvc_pkg::BSelS2: b_op = s[2];
      default:         b_op = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= a_op * b_op;
  end

  assign pext   = EW'(prod_q);
  assign pshift = pext <<< HW;
  assign dabs   = TW'(d_q[TW-1] ? -d_q : d_q);

  // divider set-up: round(num * 2^F / den4) as (num * 2^(F+1) + den4) / (2 * den4)
  assign den4     = cmd_i.tet ? DNW'(4) : DNW'({vsum_q, 2'b00});
  assign dvs      = cmd_i.tet ? DVW'(8) : DVW'({vsum_q, 3'b000});
  assign mag      = AW'(acc_q[cmd_i.axis][AW-1] ? -acc_q[cmd_i.axis] : acc_q[cmd_i.axis]);
  assign dividend = (XW'(mag) << (FRAC_BITS + 1)) + XW'(den4);
  assign rem2     = {rem_q[DVW-1:0], qs_q[QB-1]};
  assign ge       = (rem2 >= {1'b0, dvs});
  assign qc       = (ovf_q || (qs_q > cvc_pkg::CentSat)) ? cvc_pkg::CentSat : qs_q;
  assign cent     = neg_q ? (~qc + 24'd1) : ((qc == cvc_pkg::CentSat) ? cvc_pkg::CentMax : qc);
  assign vsum_ext = SVW'(vsum_q);
  assign vsum_sat = (vsum_ext > SVW'({OVW{1'b1}})) ? {OVW{1'b1}} : OVW'(vsum_ext);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      cvc_pkg::OpClr: begin
        vsum_q <= '0;
        for (int k = 0; k < 3; k++) begin
          acc_q[k] <= '0;
        end
      end
      cvc_pkg::OpXSet: x_q <= pext[CW-1:0];
      cvc_pkg::OpXSub: x_q <= x_q - pext[CW-1:0];
      cvc_pkg::OpDSet: d_q <= pext[TW-1:0];
      cvc_pkg::OpDAdd: d_q <= d_q + pext[TW-1:0];
      cvc_pkg::OpDSub: d_q <= d_q - pext[TW-1:0];
      cvc_pkg::OpVol: begin
        w_q    <= cmd_i.tet ? TW'(1) : dabs;
        vsum_q <= vsum_q + VW'(dabs);
      end
      cvc_pkg::OpALo: acc_q[cmd_i.axis] <= acc_q[cmd_i.axis] + pext[AW-1:0];
      cvc_pkg::OpAHi: acc_q[cmd_i.axis] <= acc_q[cmd_i.axis] + pshift[AW-1:0];
      cvc_pkg::OpDInit: begin
        neg_q <= acc_q[cmd_i.axis][AW-1];
        // a quotient of 2^QB or more saturates anyway
        ovf_q <= (CMW'(dividend) >= (CMW'(dvs) << QB));
        rem_q <= (DVW + 1)'(dividend >> QB);
        qs_q  <= dividend[QB-1:0];
      end
      cvc_pkg::OpDStep: begin
        rem_q <= ge ? (rem2 - {1'b0, dvs}) : rem2;
        qs_q  <= {qs_q[QB-2:0], ge};
      end
      cvc_pkg::OpDDone: cent_q[cmd_i.axis] <= cent;
      cvc_pkg::OpOut: begin
        status_q <= cmd_i.status;
        if (cmd_i.status == cvc_pkg::StOk) begin
          six_q <= vsum_sat;
          cx_q  <= cent_q[0];
          cy_q  <= cent_q[1];
          cz_q  <= cent_q[2];
        end else begin
          six_q <= '0;
          cx_q  <= '0;
          cy_q  <= '0;
          cz_q  <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.vsum_zero = (vsum_q == '0);
  assign status_o         = status_q;
  assign six_volume_o     = six_q;
  assign centroid_x_o     = $signed(cx_q);
  assign centroid_y_o     = $signed(cy_q);
  assign centroid_z_o     = $signed(cz_q);

endmodule

@@ src/cell_volume_centroid_unit.sv @@
// Volume and centroid of one mesh cell. Nodes arrive one per transfer, and
// the transfer with last_node set closes the cell. A cell of 4, 5, 6 or 8
// nodes is cut into 1, 2, 3 or 6 tetrahedra; each takes node-store reads,
// then 19 steps through one shared multiplier. Three long divisions for the
// centroid axes follow, then the output register is loaded. A bad node count
// goes from the close straight to the output load; a zero-volume cell
// other than a tetrahedron is reported only once all its tetrahedra are
// summed. A finished result is held in the output register while nodes of
// the next cell are loaded.
module cell_volume_centroid_unit #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cvc_in_if.sink    in_if,
  cvc_out_if.source out_if
);

  cvc_pkg::cvc_cmd_t  cmd;
  cvc_pkg::cvc_stat_t stat;

  cvc_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_last_i   (in_if.last_node),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cvc_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .node_x_i     (in_if.node_x),
    .node_y_i     (in_if.node_y),
    .node_z_i     (in_if.node_z),
    .stat_o       (stat),
    .status_o     (out_if.status),
    .six_volume_o (out_if.six_volume),
    .centroid_x_o (out_if.centroid_x),
    .centroid_y_o (out_if.centroid_y),
    .centroid_z_o (out_if.centroid_z)
  );

endmodule

@@ src/cvc_checker.sv @@
`include "cell_volume_centroid_unit_macros.svh"

module cvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [57:0] six_volume_i,
  input logic [23:0] centroid_x_i,
  input logic [23:0] centroid_y_i,
  input logic [23:0] centroid_z_i
);

`CVC_ASSERT_CLK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(six_volume_i), "result changed while stalled")
`CVC_ASSERT_CLK(a_close_busy, in_valid_i && in_ready_i && in_last_i |=> !in_ready_i, "node taken right after a cell close")
`CVC_ASSERT_CLK(a_status_code, out_valid_i |-> status_i == cvc_pkg::StOk || status_i == cvc_pkg::StBadCount || status_i == cvc_pkg::StZeroVol, "undefined status code")
`CVC_ASSERT_CLK(a_fail_zero, out_valid_i && status_i != cvc_pkg::StOk |-> six_volume_i == 58'd0 && centroid_x_i == 24'd0 && centroid_y_i == 24'd0 && centroid_z_i == 24'd0, "failed cell carries non-zero fields")

endmodule

bind cell_volume_centroid_unit cvc_checker u_cvc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .in_last_i    (in_if.last_node),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .status_i     (out_if.status),
  .six_volume_i (out_if.six_volume),
  .centroid_x_i (out_if.centroid_x),
  .centroid_y_i (out_if.centroid_y),
  .centroid_z_i (out_if.centroid_z)
);

@@ verif/testbench.sv @@
module testbench;

  typedef struct packed {
    logic [1:0]  status;
    logic [57:0] six_volume;
    logic [23:0] cx;
    logic [23:0] cy;
    logic [23:0] cz;
  } cell_res_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               last;
    bit                 typed;
    cell_res_t          res;
  } node_row_t;

  localparam int unsigned WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cvc_in_if  in_if ();
  cvc_out_if out_if ();

  cell_volume_centroid_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the cell being loaded
  logic signed [15:0] cell_nodes [cvc_pkg::MaxNodes][3];
  int unsigned        cell_fill;
  bit                 cell_spill;

  cell_res_t   pending_cells [$];
  int unsigned n_errors;
  int unsigned tx_idle, rx_stall;
  int unsigned quiet_cycles;

  function automatic longint unsigned leaf_six_vol(int row);
    longint u [3], v [3], w [3], det;
    for (int k = 0; k < 3; k++) begin
      u[k] = longint'(cell_nodes[cvc_pkg::LeafTets[row][1]][k])
           - cell_nodes[cvc_pkg::LeafTets[row][0]][k];
      v[k] = longint'(cell_nodes[cvc_pkg::LeafTets[row][2]][k])
           - cell_nodes[cvc_pkg::LeafTets[row][0]][k];
      w[k] = longint'(cell_nodes[cvc_pkg::LeafTets[row][3]][k])
           - cell_nodes[cvc_pkg::LeafTets[row][0]][k];
    end
    det = u[0] * (v[1] * w[2] - v[2] * w[1])
        - u[1] * (v[0] * w[2] - v[2] * w[0])
        + u[2] * (v[0] * w[1] - v[1] * w[0]);
    return (det < 0) ? longint'(-det) : det;
  endfunction

  // round(num * 2^8 / den4), ties away from zero, saturated
  function automatic logic [23:0] fix_axis(logic signed [127:0] num, logic [127:0] den4);
    logic        neg;
    logic [127:0] mag, q;
    longint       r;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = mag << 9;
    q = (mag + den4) / (den4 * 2);
    if (q > 128'h800000) q = 128'h800000;
    r = neg ? -longint'(q) : longint'(q);
    if (r > 64'sh7FFFFF) r = 64'sh7FFFFF;
    return r[23:0];
  endfunction

  function automatic bit centroid_step(input logic signed [15:0] x, y, z, input logic last,
                                       output cell_res_t res);
    int unsigned        n, first, cnt;
    longint unsigned    vol [6], vsum, wgt;
    logic signed [127:0] acc [3], s128;
    longint             s;
    bit                 tet;
    res = '0;
    if (cell_fill < cvc_pkg::MaxNodes) begin
      cell_nodes[cell_fill][0] = x;
      cell_nodes[cell_fill][1] = y;
      cell_nodes[cell_fill][2] = z;
      cell_fill++;
    end else begin
      cell_spill = 1'b1;
    end
    if (!last) return 1'b0;
    n = cell_fill;
    cell_fill = 0;
    if (cell_spill || !(n == 4 || n == 5 || n == 6 || n == 8)) begin
      cell_spill = 1'b0;
      res.status = cvc_pkg::StBadCount;
      return 1'b1;
    end
    first = (n == 4) ? 0 : (n == 5) ? 1 : (n == 6) ? 3 : 6;
    cnt   = (n == 4) ? 1 : (n == 5) ? 2 : (n == 6) ? 3 : 6;
    tet   = (n == 4);
    vsum  = 0;
    for (int i = 0; i < cnt; i++) begin
      vol[i] = leaf_six_vol(first + i);
      vsum += vol[i];
    end
    if (!tet && vsum == 0) begin
      res.status = cvc_pkg::StZeroVol;
      return 1'b1;
    end
    res.six_volume = vsum[57:0];
    acc = '{default: '0};
    for (int i = 0; i < cnt; i++) begin
      wgt = tet ? 64'd1 : vol[i];
      for (int k = 0; k < 3; k++) begin
        s = 0;
        for (int j = 0; j < 4; j++) s += cell_nodes[cvc_pkg::LeafTets[first + i][j]][k];
        s128 = s;
        acc[k] += $signed({64'd0, wgt}) * s128;
      end
    end
    res.cx = fix_axis(acc[0], 128'(4 * (tet ? 64'd1 : vsum)));
    res.cy = fix_axis(acc[1], 128'(4 * (tet ? 64'd1 : vsum)));
    res.cz = fix_axis(acc[2], 128'(4 * (tet ? 64'd1 : vsum)));
    res.status = cvc_pkg::StOk;
    return 1'b1;
  endfunction

  task automatic send_node(node_row_t row);
    cell_res_t res;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.node_x    <= row.x;
    in_if.node_y    <= row.y;
    in_if.node_z    <= row.z;
    in_if.last_node <= row.last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (centroid_step(row.x, row.y, row.z, row.last, res))
      pending_cells.push_back(row.typed ? row.res : res);
  endtask

  always @(negedge clk_i) out_if.ready <= ($urandom_range(99) >= rx_stall);

  always @(posedge clk_i) begin
    cell_res_t want;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WatchLimit) begin
        $display("Regression FAIL");
        $finish;
      end
      if (out_if.valid && out_if.ready) begin
        if (pending_cells.size() == 0) begin
          $error("unexpected result transfer");
          n_errors++;
        end else begin
          want = pending_cells.pop_front();
          if (out_if.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, out_if.status); n_errors++;
          end
          if (out_if.six_volume !== want.six_volume) begin
            $error("six_volume exp %0d got %0d", want.six_volume, out_if.six_volume);
            n_errors++;
          end
          if (out_if.centroid_x !== want.cx) begin
            $error("centroid_x exp %0d got %0d", $signed(want.cx), out_if.centroid_x);
            n_errors++;
          end
          if (out_if.centroid_y !== want.cy) begin
            $error("centroid_y exp %0d got %0d", $signed(want.cy), out_if.centroid_y);
            n_errors++;
          end
          if (out_if.centroid_z !== want.cz) begin
            $error("centroid_z exp %0d got %0d", $signed(want.cz), out_if.centroid_z);
            n_errors++;
          end
        end
      end
    end
  end

  function automatic logic signed [15:0] pick_coord(int unsigned mode);
    case (mode)
      0: return 16'($urandom);
      1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  node_row_t directed [$];
  node_row_t row;
  cell_res_t zero_res;

  initial begin
    int unsigned sent, n, mode;
    bit flat;
    in_if.valid = 1'b0;
    in_if.node_x = '0;
    in_if.node_y = '0;
    in_if.node_z = '0;
    in_if.last_node = 1'b0;
    out_if.ready = 1'b0;
    cell_fill = 0;
    cell_spill = 1'b0;
    n_errors = 0;
    quiet_cycles = 0;
    tx_idle = 0;
    rx_stall = 0;
    zero_res = '0;

    // lone node closing a cell: bad count
    row = '{x: 16'sd5, y: -16'sd5, z: 16'sd0, last: 1'b1, typed: 1'b1, res: zero_res};
    row.res.status = cvc_pkg::StBadCount;
    directed.push_back(row);
    // unit tetrahedron: volume one sixth, centroid (0.25, 0.25, 0.25)
    directed.push_back('{0, 0, 0, 0, 0, zero_res});
    directed.push_back('{1, 0, 0, 0, 0, zero_res});
    directed.push_back('{0, 1, 0, 0, 0, zero_res});
    row = '{x: 0, y: 0, z: 1, last: 1'b1, typed: 1'b1, res: zero_res};
    row.res = '{status: cvc_pkg::StOk, six_volume: 58'd1, cx: 24'd64, cy: 24'd64,
                cz: 24'd64};
    directed.push_back(row);
    // pyramid spanning the full coordinate range
    directed.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 0, 0, zero_res});
    directed.push_back('{16'sh7FFF, 16'sh8000, 16'sh8000, 0, 0, zero_res});
    directed.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 0, 0, zero_res});
    directed.push_back('{16'sh8000, 16'sh7FFF, 16'sh8000, 0, 0, zero_res});
    directed.push_back('{16'sh0000, 16'sh0000, 16'sh7FFF, 1, 0, zero_res});
    // flat prism: zero volume
    for (int i = 0; i < 5; i++) directed.push_back('{16'(i * 7), 16'(i * i), 0, 0, 0, zero_res});
    row = '{x: 3, y: 9, z: 0, last: 1'b1, typed: 1'b1, res: zero_res};
    row.res.status = cvc_pkg::StZeroVol;
    directed.push_back(row);
    // nine nodes: store overflow
    for (int i = 0; i < 8; i++) directed.push_back('{0, 0, 0, 0, 0, zero_res});
    row = '{x: 0, y: 0, z: 0, last: 1'b1, typed: 1'b1, res: zero_res};
    row.res.status = cvc_pkg::StBadCount;
    directed.push_back(row);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_node(directed[i]);

    sent = 0;
    while (sent < 1550) begin
      case ((sent / 97) % 4)
        0: begin tx_idle = 0;  rx_stall = 0;  end
        1: begin tx_idle = 81; rx_stall = 0;  end
        2: begin tx_idle = 0;  rx_stall = 81; end
        default: begin tx_idle = 6; rx_stall = 6; end
      endcase
      if ($urandom_range(99) < 85) begin
        case ($urandom_range(3))
          0: n = 4;
          1: n = 5;
          2: n = 6;
          default: n = 8;
        endcase
      end else begin
        n = $urandom_range(10, 1);
      end
      mode = $urandom_range(9) < 3 ? 0 : ($urandom_range(9) == 0 ? 1 : 2);
      flat = ($urandom_range(19) == 0);
      for (int i = 0; i < n; i++) begin
        row.x = pick_coord(mode);
        row.y = pick_coord(mode);
        row.z = flat ? 16'sd0 : pick_coord(mode);
        row.last = (i == n - 1);
        row.typed = 1'b0;
        row.res = zero_res;
        send_node(row);
        sent++;
      end
    end
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    rx_stall = 0;

    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
